@@ sv/first_fit_header_allocator_assert.svh @@
// assertion macros shared by the allocator modules
`ifndef FIRST_FIT_HEADER_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEADER_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ffha assertion failed");
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha assertion failed");
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop)
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ffha_pkg.sv @@
package ffha_pkg;

  localparam int REQ_W        = 15;
  localparam int OFF_W        = 14;
  localparam int NEED_W       = 16;
  localparam int INIT_PAYLOAD = 64;
  localparam int ROUND_MASK   = 3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR,
    DP_RD_POS,
    DP_RD_NXT,
    DP_RD_FREE,
    DP_SPLIT,
    DP_KEEP,
    DP_MERGE_START,
    DP_STEP_POS,
    DP_MERGE_FAIL,
    DP_ABSORB,
    DP_WR_HDR,
    DP_WR_FREE
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_ALLOC_OK,
    RES_FREE
  } res_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
    res_e   res;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic zero_req;
    logic free_ok;
    logic pos_end;
    logic nxt_end;
    logic hdr_flag;
    logic fits;
    logic split_ok;
    logic merge_fit;
    logic clr_last;
  } dp_status_t;

endpackage

@@ sv/first_fit_header_allocator.sv @@
// First-fit allocator over a byte arena kept as a chain of block headers, one
// header store word per 4 arena bytes. After reset a clearing pass writes the
// initial free blocks, one store word per cycle; no transaction is accepted
// until it ends. A free reads the header ahead of its offset and writes it back
// marked free; an offset below the header size, misaligned or past the arena
// is ignored. An allocate visits headers on the chain walk and on the merge of
// following free blocks alike, and each header is one read of the single-port
// header store followed by a check of it. One item is in work at a time; the
// finished result sits in an output register so the next transaction is
// accepted while it waits to be taken.
module first_fit_header_allocator import ffha_pkg::*; #(
  parameter int ARENA_BYTES     = 16384,
  parameter int MIN_SPLIT_BYTES = 64,
  parameter int HEADER_BYTES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size [14:0], free_offset [28:15]
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // block_offset [13:0]
  output logic        m_axis_tuser   // success
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [OFF_W-1:0] block_offset;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ffha_datapath #(
    .ARENA_BYTES     (ARENA_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (s_axis_tuser),
    .request_size_i (s_axis_tdata[REQ_W-1:0]),
    .free_offset_i  (s_axis_tdata[REQ_W+OFF_W-1:REQ_W]),
    .success_o      (m_axis_tuser),
    .block_offset_o (block_offset)
  );

  assign m_axis_tdata = {{(16 - OFF_W){1'b0}}, block_offset};

endmodule

@@ sv/ffha_datapath.sv @@
`include "first_fit_header_allocator_assert.svh"

module ffha_datapath import ffha_pkg::*; #(
  parameter int ARENA_BYTES     = 16384,
  parameter int MIN_SPLIT_BYTES = 64,
  parameter int HEADER_BYTES    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  logic             req_type_i,
  input  logic [REQ_W-1:0] request_size_i,
  input  logic [OFF_W-1:0] free_offset_i,
  output logic             success_o,
  output logic [OFF_W-1:0] block_offset_o
);

  localparam int DEPTH  = ARENA_BYTES / 4;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(ARENA_BYTES) + 1;
  localparam int ENT_W  = SIZE_W + 1;
  localparam int POS_W  = $clog2(ARENA_BYTES) + 2;
  localparam int DW     = ((POS_W > NEED_W) ? POS_W : NEED_W) + 2;
  localparam int STRIDE = INIT_PAYLOAD + HEADER_BYTES;

  localparam logic [DW-1:0] ARENA_D  = DW'(ARENA_BYTES);
  localparam logic [DW-1:0] DEPTH_D  = DW'(DEPTH);
  localparam logic [DW-1:0] HDR_D    = DW'(HEADER_BYTES);
  localparam logic [DW-1:0] MIN_D    = DW'(MIN_SPLIT_BYTES);
  localparam logic [DW-1:0] STRIDE_D = DW'(STRIDE);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_q;
  logic             rd_in_q;

  logic             mem_we;
  logic [DW-1:0]    mem_idx;
  logic [ENT_W-1:0] mem_wdata;
  logic             idx_in;

  // clearing pass
  logic [ADDR_W-1:0] clr_idx_q;
  logic [DW-1:0]     hdr_pos_q;
  logic              clr_hit;
  logic              init_ok;

  // walk registers
  logic [DW-1:0]     pos_q, nxt_q, acc_q, tot_q, step_q, hpos_q;
  logic [NEED_W-1:0] need_q;
  logic [SIZE_W-1:0] wsize_q;
  logic              kind_q, zero_q, free_ok_q;
  logic              success_q;
  logic [OFF_W-1:0]  offset_q;

  logic [ENT_W-1:0]  hdr;
  logic              hdr_flag;
  logic [DW-1:0]     hdr_size;
  logic [DW-1:0]     need_w;
  logic [DW-1:0]     excess;
  logic [DW-1:0]     split_pos;
  logic [DW-1:0]     acc_sum;
  logic              fits;
  logic              split_ok;
  logic [NEED_W-1:0] need_d;
  logic [DW-1:0]     off_w;
  logic [DW-1:0]     hpos_d;

  // a read past the last word gives a zero header
  assign hdr       = rd_in_q ? rdata_q : '0;
  assign hdr_flag  = hdr[ENT_W-1];
  assign hdr_size  = DW'(hdr[SIZE_W-1:0]);
  assign need_w    = DW'(need_q);
  assign fits      = hdr_size >= need_w;
  assign excess    = hdr_size - need_w;
  assign split_ok  = fits && (excess >= MIN_D) && (excess >= HDR_D);
  assign split_pos = pos_q + HDR_D + need_w;
  assign acc_sum   = acc_q + hdr_size;

  assign need_d = (NEED_W'(request_size_i) + NEED_W'(ROUND_MASK)) & ~NEED_W'(ROUND_MASK);
  assign off_w  = DW'(free_offset_i);
  assign hpos_d = off_w - HDR_D;

  assign clr_hit = (hdr_pos_q >> 2) == DW'(clr_idx_q);
  assign init_ok = (hdr_pos_q + STRIDE_D) < ARENA_D;

  always_comb begin
    mem_idx   = '0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (cmd_i.op)
      DP_CLR: begin
        mem_idx   = DW'(clr_idx_q);
        mem_we    = 1'b1;
        mem_wdata = (clr_hit && init_ok) ? ENT_W'(INIT_PAYLOAD) : '0;
      end
      DP_RD_POS:  mem_idx = pos_q >> 2;
      DP_RD_NXT:  mem_idx = nxt_q >> 2;
      DP_RD_FREE: mem_idx = hpos_q >> 2;
      DP_SPLIT: begin
        mem_idx   = split_pos >> 2;
        mem_we    = 1'b1;
        mem_wdata = {1'b0, SIZE_W'(excess - HDR_D)};
      end
      DP_WR_HDR: begin
        mem_idx   = pos_q >> 2;
        mem_we    = 1'b1;
        mem_wdata = {1'b1, wsize_q};
      end
      DP_WR_FREE: begin
        mem_idx   = hpos_q >> 2;
        mem_we    = 1'b1;
        mem_wdata = {1'b0, hdr[SIZE_W-1:0]};
      end
      default: begin
        mem_idx = '0;
      end
    endcase
  end

  assign idx_in = mem_idx < DEPTH_D;

  always_ff @(posedge clk_i) begin
    if (mem_we && idx_in) begin
      mem[mem_idx[ADDR_W-1:0]] <= mem_wdata;
    end
    rdata_q <= mem[mem_idx[ADDR_W-1:0]];
    rd_in_q <= idx_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      hdr_pos_q <= '0;
    end else if (cmd_i.op == DP_CLR) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_hit && init_ok) begin
        hdr_pos_q <= hdr_pos_q + STRIDE_D;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        kind_q    <= req_type_i;
        zero_q    <= (request_size_i == '0);
        need_q    <= need_d;
        hpos_q    <= hpos_d;
        free_ok_q <= (off_w >= HDR_D) && (hpos_d[1:0] == 2'b00) && (hpos_d < ARENA_D);
        pos_q     <= '0;
      end
      DP_SPLIT:    wsize_q <= SIZE_W'(need_w);
      DP_KEEP:     wsize_q <= hdr[SIZE_W-1:0];
      DP_STEP_POS: pos_q   <= pos_q + hdr_size + HDR_D;
      DP_MERGE_START: begin
        acc_q  <= hdr_size;
        tot_q  <= hdr_size;
        nxt_q  <= pos_q + hdr_size + HDR_D;
        step_q <= pos_q + hdr_size + HDR_D;
      end
      DP_MERGE_FAIL: pos_q <= step_q;
      DP_ABSORB: begin
        acc_q   <= acc_sum;
        tot_q   <= tot_q + hdr_size + HDR_D;
        nxt_q   <= nxt_q + hdr_size + HDR_D;
        wsize_q <= SIZE_W'(tot_q + hdr_size + HDR_D);
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      case (cmd_i.res)
        RES_ALLOC_OK: begin
          success_q <= 1'b1;
          offset_q  <= OFF_W'(pos_q + HDR_D);
        end
        RES_FREE: begin
          success_q <= 1'b1;
          offset_q  <= '0;
        end
        default: begin
          success_q <= 1'b0;
          offset_q  <= '0;
        end
      endcase
    end
  end

  assign success_o      = success_q;
  assign block_offset_o = offset_q;

  assign status_o.kind      = kind_q;
  assign status_o.zero_req  = zero_q;
  assign status_o.free_ok   = free_ok_q;
  assign status_o.pos_end   = pos_q >= ARENA_D;
  assign status_o.nxt_end   = nxt_q >= ARENA_D;
  assign status_o.hdr_flag  = hdr_flag;
  assign status_o.fits      = fits;
  assign status_o.split_ok  = split_ok;
  assign status_o.merge_fit = acc_sum >= need_w;
  assign status_o.clr_last  = clr_idx_q == ADDR_W'(DEPTH - 1);

  `FFHA_ASSERT(a_split_needs_room, clk_i, rst_ni, (cmd_i.op == DP_SPLIT) |-> split_ok)
  `FFHA_ASSERT(a_absorb_free_only, clk_i, rst_ni, (cmd_i.op == DP_ABSORB) |-> !hdr_flag)
  `FFHA_ASSERT(a_hdr_write_in_arena, clk_i, rst_ni, (cmd_i.op == DP_WR_HDR) |-> idx_in)

endmodule

@@ sv/ffha_ctrl.sv @@
`include "first_fit_header_allocator_assert.svh"

module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_MERGE_RD,
    ST_MERGE_CHK,
    ST_WR_HDR,
    ST_FREE_WR,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   m_valid_q;

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    cmd_o.op     = DP_NOP;
    cmd_o.out_load = 1'b0;
    cmd_o.res    = res_q;
    s_tready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = DP_CLR;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        if (status_i.kind) begin
          if (status_i.free_ok) begin
            cmd_o.op = DP_RD_FREE;
            state_d  = ST_FREE_WR;
          end else begin
            res_d   = RES_FREE;
            state_d = ST_RESP;
          end
        end else if (status_i.zero_req) begin
          res_d   = RES_FAIL;
          state_d = ST_RESP;
        end else begin
          state_d = ST_ALLOC_RD;
        end
      end
      ST_ALLOC_RD: begin
        if (status_i.pos_end) begin
          res_d   = RES_FAIL;
          state_d = ST_RESP;
        end else begin
          cmd_o.op = DP_RD_POS;
          state_d  = ST_ALLOC_CHK;
        end
      end
      ST_ALLOC_CHK: begin
        if (status_i.hdr_flag) begin
          cmd_o.op = DP_STEP_POS;
          state_d  = ST_ALLOC_RD;
        end else if (status_i.fits) begin
          cmd_o.op = status_i.split_ok ? DP_SPLIT : DP_KEEP;
          state_d  = ST_WR_HDR;
        end else begin
          cmd_o.op = DP_MERGE_START;
          state_d  = ST_MERGE_RD;
        end
      end
      ST_MERGE_RD: begin
        if (status_i.nxt_end) begin
          cmd_o.op = DP_MERGE_FAIL;
          state_d  = ST_ALLOC_RD;
        end else begin
          cmd_o.op = DP_RD_NXT;
          state_d  = ST_MERGE_CHK;
        end
      end
      ST_MERGE_CHK: begin
        if (status_i.hdr_flag) begin
          cmd_o.op = DP_MERGE_FAIL;
          state_d  = ST_ALLOC_RD;
        end else begin
          cmd_o.op = DP_ABSORB;
          state_d  = status_i.merge_fit ? ST_WR_HDR : ST_MERGE_RD;
        end
      end
      ST_WR_HDR: begin
        cmd_o.op = DP_WR_HDR;
        res_d    = RES_ALLOC_OK;
        state_d  = ST_RESP;
      end
      ST_FREE_WR: begin
        cmd_o.op = DP_WR_FREE;
        res_d    = RES_FREE;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        // wait for the output register to drain
        if (!m_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      res_q     <= RES_FAIL;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;

  `FFHA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, s_tvalid_i && s_tready_o, state_q != ST_IDLE)
  `FFHA_ASSERT_NEXT(a_clear_runs_once, clk_i, rst_ni, state_q != ST_CLEAR, state_q != ST_CLEAR)
  `FFHA_ASSERT_NEXT(a_result_waits, clk_i, rst_ni, (state_q == ST_RESP) && m_valid_q && !m_tready_i, state_q == ST_RESP)

endmodule

@@ test/ffha_tb_pkg.sv @@
package ffha_tb_pkg;

  // request kind carried on s_axis_tuser
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_e;

endpackage

@@ test/ffha_checker.sv @@
module ffha_checker import ffha_pkg::*, ffha_tb_pkg::*; #(
  parameter int ARENA_BYTES     = 16384,
  parameter int MIN_SPLIT_BYTES = 64,
  parameter int HEADER_BYTES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size [14:0], free_offset [28:15]
  input  logic        s_axis_tuser,  // req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // block_offset [13:0]
  input  logic        m_axis_tuser,  // success
  output int          mismatch_count_o,
  output int          replies_owed_o
);

  localparam int WORDS    = ARENA_BYTES / 4;
  localparam int FLAG_BIT = 31;

  typedef struct packed {
    logic             granted;
    logic [OFF_W-1:0] offset;
  } reply_t;

  // shadow of the header store, one word per 4 arena bytes
  logic [31:0] header_words [WORDS];
  reply_t      owed_replies [$];
  int          mismatches;

  function automatic logic [31:0] peek_header(longint unsigned pos);
    longint unsigned idx;
    idx = pos >> 2;
    if (idx < WORDS) return header_words[idx];
    return '0;
  endfunction

  function automatic void poke_header(longint unsigned pos, logic [31:0] val);
    longint unsigned idx;
    idx = pos >> 2;
    if (idx < WORDS) header_words[idx] = val;
  endfunction

  // first-fit walk with split of large excess and merge of following free blocks
  function automatic longint unsigned predict_alloc(logic [REQ_W-1:0] req);
    longint unsigned need, pos, bsz, excess, acc, nxt, absorbed;
    logic [31:0]     h, g;
    bit              found;
    if (req == 0) return 0;
    need = req + ROUND_MASK;
    need = need & ~64'(ROUND_MASK);
    pos = 0;
    while (pos < ARENA_BYTES) begin
      h = peek_header(pos);
      bsz = h[30:0];
      if (h[FLAG_BIT]) begin
        pos += bsz + HEADER_BYTES;
        continue;
      end
      if (bsz >= need) begin
        excess = bsz - need;
        if (excess >= MIN_SPLIT_BYTES && excess >= HEADER_BYTES) begin
          poke_header(pos + HEADER_BYTES + need, {1'b0, 31'(excess - HEADER_BYTES)});
          bsz = need;
        end
        poke_header(pos, {1'b1, 31'(bsz)});
        return pos + HEADER_BYTES;
      end
      acc = bsz;
      absorbed = 0;
      found = 1'b0;
      nxt = pos + bsz + HEADER_BYTES;
      while (nxt < ARENA_BYTES) begin
        g = peek_header(nxt);
        if (g[FLAG_BIT]) break;
        acc += g[30:0];
        absorbed++;
        if (acc >= need) begin
          found = 1'b1;
          break;
        end
        nxt += g[30:0] + HEADER_BYTES;
      end
      if (found) begin
        poke_header(pos, {1'b1, 31'(acc + absorbed * HEADER_BYTES)});
        return pos + HEADER_BYTES;
      end
      pos += bsz + HEADER_BYTES;
    end
    return 0;
  endfunction

  function automatic void predict_free(logic [OFF_W-1:0] off);
    longint unsigned hpos;
    logic [31:0]     h;
    if (off < HEADER_BYTES) return;
    hpos = off - HEADER_BYTES;
    if ((hpos & ROUND_MASK) != 0 || hpos >= ARENA_BYTES) return;
    h = peek_header(hpos);
    h[FLAG_BIT] = 1'b0;
    poke_header(hpos, h);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint unsigned p, granted_at;
    reply_t          want, next_reply;
    req_kind_e       kind;
    if (!rst_ni) begin
      for (int w = 0; w < WORDS; w++) header_words[w] = '0;
      p = 0;
      while (p + INIT_PAYLOAD + HEADER_BYTES < ARENA_BYTES) begin
        poke_header(p, INIT_PAYLOAD);
        p += INIT_PAYLOAD + HEADER_BYTES;
      end
      owed_replies.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      replies_owed_o <= 0;
    end else begin
      // retire first so a stray reply never consumes a same-edge prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("reply with nothing owed", m_axis_tdata[OFF_W-1:0], 0);
        end else begin
          want = owed_replies.pop_front();
          if (m_axis_tuser !== want.granted)
            report_mismatch("success", m_axis_tuser, want.granted);
          if (m_axis_tdata[OFF_W-1:0] !== want.offset)
            report_mismatch("block_offset", m_axis_tdata[OFF_W-1:0], want.offset);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        kind = req_kind_e'(s_axis_tuser);
        if (kind == REQ_ALLOC) begin
          granted_at = predict_alloc(s_axis_tdata[REQ_W-1:0]);
          next_reply.granted = (granted_at != 0);
          next_reply.offset  = granted_at[OFF_W-1:0];
        end else begin
          predict_free(s_axis_tdata[REQ_W +: OFF_W]);
          next_reply.granted = 1'b1;
          next_reply.offset  = '0;
        end
        owed_replies.push_back(next_reply);
      end
      replies_owed_o <= owed_replies.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

@@ test/tb_first_fit_header_allocator.sv @@
module tb_first_fit_header_allocator;
  import ffha_pkg::*;
  import ffha_tb_pkg::*;

  localparam int ARENA_BYTES     = 16384;
  localparam int MIN_SPLIT_BYTES = 64;
  localparam int HEADER_BYTES    = 8;
  localparam int ITEMS_PER_PHASE = 530;
  localparam int LIVE_CAP        = 120;
  localparam int HOLD_AT         = 1300;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 20_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // request_size [14:0], free_offset [28:15]
  logic        s_axis_tuser  = REQ_ALLOC;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // block_offset [13:0]
  logic        m_axis_tuser;  // success

  int mismatch_count;
  int replies_owed;
  int send_idle_pct = 9;
  int recv_idle_pct = 46;
  int requests_sent = 0;
  int replies_seen  = 0;
  int grants_seen   = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  // payload offsets handed out and not yet freed by the random mix
  logic [OFF_W-1:0] live_blocks [$];

  first_fit_header_allocator #(
    .ARENA_BYTES    (ARENA_BYTES),
    .MIN_SPLIT_BYTES(MIN_SPLIT_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  ffha_checker #(
    .ARENA_BYTES    (ARENA_BYTES),
    .MIN_SPLIT_BYTES(MIN_SPLIT_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) reply_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count_o(mismatch_count),
    .replies_owed_o  (replies_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && requests_sent >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      replies_seen <= replies_seen + 1;
      if (m_axis_tuser && m_axis_tdata[OFF_W-1:0] != 0) begin
        grants_seen <= grants_seen + 1;
        live_blocks.push_back(m_axis_tdata[OFF_W-1:0]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[first_fit_header_allocator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(req_kind_e kind, logic [REQ_W-1:0] size, logic [OFF_W-1:0] off);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, off, size};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent <= requests_sent + 1;
  endtask

  // the field the block ignores carries random bits
  task automatic request_alloc(logic [REQ_W-1:0] size);
    offer(REQ_ALLOC, size, OFF_W'($urandom));
  endtask

  task automatic request_free(logic [OFF_W-1:0] off);
    offer(REQ_FREE, REQ_W'($urandom), off);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (replies_owed != 0) @(posedge clk_i);
  endtask

  initial begin
    int               roll, pick;
    logic [OFF_W-1:0] junk_off;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner cases against the fresh arena of 64-byte blocks
    request_alloc(0);
    request_alloc(1);
    request_alloc(64);
    request_alloc(3);
    request_free(0);
    request_free(4);
    request_free(10);
    request_free(8);
    request_alloc(65);     // too big for one block, merges two
    request_alloc(16384);
    request_alloc(200);
    request_free(100);     // aligned but not a header position
    request_free(16380);
    request_free(16383);
    request_free(224);
    request_alloc(4);
    request_alloc(4);      // lands on the merged block, splits off the rest
    request_alloc(16383);
    request_alloc(8000);
    request_alloc(13);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct <= 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct <= 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (live_blocks.size() > 0 && (roll < 40 || live_blocks.size() > LIVE_CAP)) begin
          pick = $urandom_range(0, live_blocks.size() - 1);
          junk_off = live_blocks[pick];
          live_blocks.delete(pick);
          request_free(junk_off);
        end else if (roll < 48) begin
          case ($urandom_range(0, 4))
            0: junk_off = '0;
            1: junk_off = OFF_W'($urandom_range(1, HEADER_BYTES - 1));
            2: junk_off = OFF_W'(($urandom_range(2, 4095) << 2) | $urandom_range(1, 3));
            3: junk_off = OFF_W'($urandom_range(2, 4095) << 2);
            default: junk_off = OFF_W'($urandom);
          endcase
          request_free(junk_off);
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2) request_alloc(0);
          else if (roll < 70) request_alloc(REQ_W'($urandom_range(1, 64)));
          else if (roll < 92) request_alloc(REQ_W'($urandom_range(65, 320)));
          else if (roll < 98) request_alloc(REQ_W'($urandom_range(321, 2048)));
          else request_alloc(REQ_W'($urandom_range(2049, 16384)));
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("drove %0d alloc/free requests (corner cases then random mix) under three stall mixes",
             requests_sent);
    $display("checked %0d replies, %0d of them granted allocations", replies_seen, grants_seen);
    if (mismatch_count == 0) begin
      $display("[first_fit_header_allocator] OK");
    end else begin
      $display("[first_fit_header_allocator] ERROR");
    end
    $finish;
  end

endmodule
